// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/cfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcm_pkg
// shared types and constants of the card frame check and match unit
// ----------------------------------------------------------------------------
package cfcm_pkg;

    localparam int LIST_SIZE = 4;
    localparam int CARD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] FRAME_LEN  = 4'd12;
    localparam logic [POS_W-1:0] IDLE_POS   = 4'd12;
    localparam logic [POS_W-1:0] LAST_POS   = 4'd11;
    localparam logic [POS_W-1:0] HDR_LEN    = 4'd4;
    localparam logic [POS_W-1:0] STATUS_POS = 4'd4;
    localparam logic [POS_W-1:0] CARD_FIRST = 4'd7;
    localparam logic [POS_W-1:0] CARD_LAST  = 4'd10;

    localparam logic [BYTE_W-1:0] HDR_BYTE_0  = 8'h04;
    localparam logic [BYTE_W-1:0] HDR_BYTE_1  = 8'h0C;
    localparam logic [BYTE_W-1:0] HDR_BYTE_2  = 8'h02;
    localparam logic [BYTE_W-1:0] HDR_BYTE_3  = 8'h20;
    localparam logic [BYTE_W-1:0] STATUS_GOOD = 8'h00;

    typedef enum logic [2:0] {
        VERDICT_ALLOWED      = 3'd0,
        VERDICT_NOT_LISTED   = 3'd1,
        VERDICT_BAD_HEADER   = 3'd2,
        VERDICT_BAD_CHECKSUM = 3'd3,
        VERDICT_READ_FAILED  = 3'd4
    } t_verdict;

    // card_number in the lowest bits
    typedef struct packed {
        logic                granted;
        t_verdict            verdict;
        logic [CARD_W-1:0]   card_number;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef logic [LIST_SIZE-1:0][CARD_W-1:0] t_card_list;

    function automatic logic [BYTE_W-1:0] header_byte(input logic [1:0] p);
        logic [BYTE_W-1:0] b;
        case (p)
            2'd0:    b = HDR_BYTE_0;
            2'd1:    b = HDR_BYTE_1;
            2'd2:    b = HDR_BYTE_2;
            default: b = HDR_BYTE_3;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/cfcm_parser.sv =====
// ----------------------------------------------------------------------------
// cfcm_parser
// frame position tracking, header/status/checksum checks and list match
// ----------------------------------------------------------------------------
module cfcm_parser
    import cfcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic                i_start,
    input  t_card_list          i_allowed,
    output logic                o_push,
    output t_result             o_result,
    output logic [POS_W-1:0]    o_pos
);

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [BYTE_W-1:0] r_xor,  n_xor;
    logic              r_hdr,  n_hdr;
    logic              r_stat, n_stat;
    logic [CARD_W-1:0] r_card, n_card;

    logic [POS_W-1:0]  cur_pos;
    logic [BYTE_W-1:0] cur_xor;
    logic              cur_hdr;
    logic              cur_stat;
    logic [CARD_W-1:0] cur_card;
    logic              active;
    logic              last;
    logic              sum_ok;
    logic              listed;
    t_verdict          verdict;

    always_comb begin
        cur_pos  = i_start ? '0 : r_pos;
        cur_xor  = i_start ? '0 : r_xor;
        cur_hdr  = i_start ? 1'b1 : r_hdr;
        cur_stat = i_start ? 1'b0 : r_stat;
        cur_card = i_start ? '0 : r_card;

        active = cur_pos < FRAME_LEN;
        last   = cur_pos == LAST_POS;
        sum_ok = i_byte == ~cur_xor;

        listed = 1'b0;
        for (int i = 0; i < LIST_SIZE; i++) begin
            if (i_allowed[i] == cur_card) begin
                listed = 1'b1;
            end
        end

        if (!cur_hdr) begin
            verdict = VERDICT_BAD_HEADER;
        end else if (!sum_ok) begin
            verdict = VERDICT_BAD_CHECKSUM;
        end else if (cur_stat) begin
            verdict = VERDICT_READ_FAILED;
        end else if (listed) begin
            verdict = VERDICT_ALLOWED;
        end else begin
            verdict = VERDICT_NOT_LISTED;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_xor  = r_xor;
        n_hdr  = r_hdr;
        n_stat = r_stat;
        n_card = r_card;
        if (i_accept) begin
            n_pos  = cur_pos;
            n_xor  = cur_xor;
            n_hdr  = cur_hdr;
            n_stat = cur_stat;
            n_card = cur_card;
            if (active) begin
                if (last) begin
                    n_pos = IDLE_POS;
                end else begin
                    if (cur_pos < HDR_LEN && i_byte != header_byte(cur_pos[1:0])) begin
                        n_hdr = 1'b0;
                    end
                    if (cur_pos == STATUS_POS) begin
                        n_stat = i_byte != STATUS_GOOD;
                    end
                    if (cur_pos >= CARD_FIRST && cur_pos <= CARD_LAST) begin
                        n_card = {cur_card[CARD_W-BYTE_W-1:0], i_byte};
                    end
                    n_xor = cur_xor ^ i_byte;
                    n_pos = cur_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= IDLE_POS;
            r_xor  <= '0;
            r_hdr  <= 1'b1;
            r_stat <= 1'b0;
            r_card <= '0;
        end else begin
            r_pos  <= n_pos;
            r_xor  <= n_xor;
            r_hdr  <= n_hdr;
            r_stat <= n_stat;
            r_card <= n_card;
        end
    end

    assign o_push               = i_accept && last;
    assign o_result.card_number = cur_card;
    assign o_result.verdict     = verdict;
    assign o_result.granted     = verdict == VERDICT_ALLOWED;
    assign o_pos                = r_pos;

endmodule

// ===== rtl/cfcm_out_stage.sv =====
// ----------------------------------------------------------------------------
// cfcm_out_stage
// result register with one skid entry
// ----------------------------------------------------------------------------
module cfcm_out_stage
    import cfcm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid, n_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_data, n_data;
    t_result r_skid, n_skid;

    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_data       = r_data;
        n_skid       = r_skid;
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                n_valid      = 1'b1;
                n_data       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_valid = i_push;
                n_data  = i_result;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_skid <= n_skid;
    end

    assign o_room   = !r_skid_valid;
    assign o_valid  = r_valid;
    assign o_result = r_data;

endmodule

// ===== rtl/card_frame_check_and_match_unit.sv =====
// ----------------------------------------------------------------------------
// card_frame_check_and_match_unit
// checks 12-byte card reader reply frames and matches the card number
// ----------------------------------------------------------------------------
// One reply byte is taken per clock while tready is high. A byte flagged with
// tuser begins a frame; on the twelfth byte the checks and the compare against
// the allowed list are done in that same cycle and the verdict is registered
// in the output register or, while that waits unread, in its one skid entry,
// so tready drops only when two verdicts wait unread. Bytes outside a frame
// and frames cut short give no verdict. The allowed list is written through
// the configuration port, which is always ready.
module card_frame_check_and_match_unit
    import cfcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,   // rx_byte
    input  logic                  i_s_tuser,   // frame_start
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata,   // card_number, verdict, granted, zero fill
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CARD_W-1:0]     i_cfg_data
);

`include "assert_macros.svh"

    t_card_list       r_allowed;
    logic             accept;
    logic             push;
    logic             room;
    t_result          parse_result;
    t_result          out_result;
    logic [POS_W-1:0] pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed <= '0;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < LIST_SIZE; i++) begin
                if (i_cfg_index == i[CFG_IDX_W-1:0]) begin
                    r_allowed[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = room;
    assign accept      = i_s_tvalid && room;

    cfcm_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_tdata),
        .i_start   (i_s_tuser),
        .i_allowed (r_allowed),
        .o_push    (push),
        .o_result  (parse_result),
        .o_pos     (pos)
    );

    cfcm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parse_result),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {{(TDATA_W-RESULT_W){1'b0}}, out_result};

    `ASSERT_PROP(a_granted_match, i_clk, i_rst_n, o_m_tvalid |-> (out_result.granted == (out_result.verdict == VERDICT_ALLOWED)), "granted disagrees with verdict")
    `ASSERT_PROP(a_result_source, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(push), "verdict without a final frame byte")
    `ASSERT_NEVER(a_pos_range, i_clk, i_rst_n, pos > IDLE_POS, "frame position out of range")

endmodule
